FILE: design/cso_pkg.sv
// ----------------------------------------------------------------------------
// cso_pkg
// Shared widths, types and helpers for the capsule/sphere overlap pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cso_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int PT_W        = 3 * COORD_WIDTH;
  localparam int RAD_W       = 16;
  localparam int DIST_W      = 34;

  localparam int DW     = COORD_WIDTH + 1;
  localparam int DOT_W  = 2 * DW + 1;
  localparam int NUM_W  = 2 * DOT_W + 1;
  localparam int PW     = COORD_WIDTH + T_FRAC_BITS + 1;
  localparam int PX_W   = PW + 2;
  localparam int EW     = PW + 1;
  localparam int SQ_W   = 2 * EW;
  localparam int D_W    = SQ_W + 2;
  localparam int VW_W   = DW + EW + 2;
  localparam int VV_W   = DOT_W + T_FRAC_BITS;
  localparam int DIV_A  = (NUM_W > VW_W) ? NUM_W : VW_W;
  localparam int DIV_W  = (DIV_A > VV_W) ? DIV_A : VV_W;
  localparam int TQ_W   = T_FRAC_BITS + 1;

  localparam logic [TQ_W-1:0]   T_ONE    = TQ_W'(1) << T_FRAC_BITS;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef logic [2:0][COORD_WIDTH-1:0] cvec_t;
  typedef logic [2:0][DW-1:0]          dvec_t;
  typedef logic [2:0][PW-1:0]          pvec_t;

  typedef struct packed {
    cvec_t            s1;
    cvec_t            s2;
    dvec_t            v1;
    dvec_t            v2;
    pvec_t            pp;
    logic [RAD_W-1:0] rad_a;
    logic [RAD_W-1:0] rad_b;
    logic             va;
    logic             vb;
    logic             z1;
    logic             z2;
    logic             sel;
    logic             use2;
    logic [D_W-1:0]   d1;
  } cso_item_t;

  // s * 2^T + t * v
  function automatic logic signed [PX_W-1:0] on_seg(logic [COORD_WIDTH-1:0] s,
                                                    logic [TQ_W-1:0] t,
                                                    logic [DW-1:0] v);
    logic signed [PX_W-1:0] a;
    logic signed [PX_W-1:0] b;
    a = PX_W'($signed(s)) <<< T_FRAC_BITS;
    b = PX_W'($signed({1'b0, t})) * PX_W'($signed(v));
    return a + b;
  endfunction

endpackage

`default_nettype wire

FILE: design/cso_div.sv
// ----------------------------------------------------------------------------
// cso_div
// Pipelined clamped quotient: one restoring step per stage, item carried along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cso_div import cso_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [DIV_W-1:0] num,
  input  logic signed [DIV_W-1:0] den,
  input  cso_item_t               in_item,
  output logic                    out_vld,
  output logic [TQ_W-1:0]         q,
  output logic                    t_in_rng,
  output cso_item_t               out_item
);

  localparam int NST = T_FRAC_BITS;

  logic             vld_r  [0:NST];
  logic             done_r [0:NST];
  logic             done_nxt [0:NST];
  logic             ins_r  [0:NST];
  logic             ins_nxt [0:NST];
  logic [TQ_W-1:0]  q_r    [0:NST];
  logic [TQ_W-1:0]  q_nxt  [0:NST];
  logic [DIV_W-1:0] rem_r  [0:NST-1];
  logic [DIV_W-1:0] rem_nxt [0:NST-1];
  logic [DIV_W-1:0] dv_r   [0:NST-1];
  logic [DIV_W-1:0] dv_nxt [0:NST-1];
  cso_item_t        it_r   [0:NST];

  always_comb begin
    logic [DIV_W:0]   r2;
    logic [DIV_W-1:0] rk;
    done_nxt[0] = 1'b1;
    ins_nxt[0]  = 1'b1;
    q_nxt[0]    = '0;
    rem_nxt[0]  = num;
    dv_nxt[0]   = den;
    if (den == '0) begin
      done_nxt[0] = 1'b1;
    end else if (num[DIV_W-1]) begin
      ins_nxt[0] = 1'b0;
    end else if (num > den) begin
      q_nxt[0]   = T_ONE;
      ins_nxt[0] = 1'b0;
    end else if (num == den) begin
      q_nxt[0] = T_ONE;
    end else begin
      done_nxt[0] = 1'b0;
    end
    for (int k = 1; k <= NST; k++) begin
      done_nxt[k] = done_r[k-1];
      ins_nxt[k]  = ins_r[k-1];
      q_nxt[k]    = q_r[k-1];
      r2          = {rem_r[k-1], 1'b0};
      rk          = rem_r[k-1];
      if (!done_r[k-1]) begin
        if (r2 >= {1'b0, dv_r[k-1]}) begin
          rk       = DIV_W'(r2 - {1'b0, dv_r[k-1]});
          q_nxt[k] = {q_r[k-1][TQ_W-2:0], 1'b1};
        end else begin
          rk       = r2[DIV_W-1:0];
          q_nxt[k] = {q_r[k-1][TQ_W-2:0], 1'b0};
        end
      end
      if (k < NST) begin
        rem_nxt[k] = rk;
        dv_nxt[k]  = dv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NST; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k <= NST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0] <= in_item;
      for (int k = 0; k <= NST; k++) begin
        done_r[k] <= done_nxt[k];
        ins_r[k]  <= ins_nxt[k];
        q_r[k]    <= q_nxt[k];
      end
      for (int k = 1; k <= NST; k++) it_r[k] <= it_r[k-1];
      for (int k = 0; k < NST; k++) begin
        rem_r[k] <= rem_nxt[k];
        dv_r[k]  <= dv_nxt[k];
      end
    end
  end

  assign out_vld  = vld_r[NST];
  assign q        = q_r[NST];
  assign t_in_rng = ins_r[NST];
  assign out_item = it_r[NST];

endmodule

`default_nettype wire

FILE: design/cso_front.sv
// ----------------------------------------------------------------------------
// cso_front
// Unpack, direction vectors, dot products and the skew-line quotient terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cso_front import cso_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [PT_W-1:0]         a_start,
  input  logic [PT_W-1:0]         a_end,
  input  logic [RAD_W-1:0]        a_radius,
  input  logic [PT_W-1:0]         b_start,
  input  logic [PT_W-1:0]         b_end,
  input  logic [RAD_W-1:0]        b_radius,
  input  logic                    a_valid,
  input  logic                    b_valid,
  output logic                    out_vld,
  output logic signed [DIV_W-1:0] num,
  output logic signed [DIV_W-1:0] den,
  output cso_item_t               out_item
);

  function automatic cvec_t unpack(logic [PT_W-1:0] word);
    cvec_t o;
    for (int i = 0; i < 3; i++) o[i] = word[i*COORD_WIDTH +: COORD_WIDTH];
    return o;
  endfunction

  function automatic logic signed [DOT_W-1:0] dot3(dvec_t x, dvec_t y);
    logic signed [DOT_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) acc = acc + DOT_W'($signed(x[i])) * DOT_W'($signed(y[i]));
    return acc;
  endfunction

  function automatic logic signed [DOT_W-1:0] xterm(logic [DW-1:0] p, logic [DW-1:0] q,
                                                    logic [DW-1:0] r, logic [DW-1:0] s);
    return DOT_W'($signed(p)) * DOT_W'($signed(q)) - DOT_W'($signed(r)) * DOT_W'($signed(s));
  endfunction

  // stage 1
  cvec_t     s1, e1, s2, e2;
  dvec_t     v1, v2, w;
  cso_item_t it1_nxt, it1_r, it2_r, it3_r, it4_r;
  dvec_t     w1_r;
  logic      vld1_r, vld2_r, vld3_r, vld4_r;

  always_comb begin
    s1 = unpack(a_start);
    e1 = unpack(a_end);
    s2 = unpack(b_start);
    e2 = unpack(b_end);
    for (int i = 0; i < 3; i++) begin
      v1[i] = DW'($signed(e1[i])) - DW'($signed(s1[i]));
      v2[i] = DW'($signed(e2[i])) - DW'($signed(s2[i]));
      w[i]  = DW'($signed(s1[i])) - DW'($signed(s2[i]));
    end
    it1_nxt       = '0;
    it1_nxt.s1    = s1;
    it1_nxt.s2    = s2;
    it1_nxt.v1    = v1;
    it1_nxt.v2    = v2;
    it1_nxt.rad_a = a_radius;
    it1_nxt.rad_b = b_radius;
    it1_nxt.va    = a_valid;
    it1_nxt.vb    = b_valid;
    it1_nxt.z1    = (v1 == '0);
    it1_nxt.z2    = (v2 == '0);
  end

  // stage 2
  logic signed [DOT_W-1:0] a2_r, b2_r, c2_r, dd2_r, ee2_r;
  logic                    cz2_r;
  logic signed [DOT_W-1:0] cx0, cx1, cx2;

  always_comb begin
    cx0 = xterm(it1_r.v1[1], it1_r.v2[2], it1_r.v1[2], it1_r.v2[1]);
    cx1 = xterm(it1_r.v1[2], it1_r.v2[0], it1_r.v1[0], it1_r.v2[2]);
    cx2 = xterm(it1_r.v1[0], it1_r.v2[1], it1_r.v1[1], it1_r.v2[0]);
  end

  // stage 3
  logic signed [NUM_W-1:0] pbe3_r, pcd3_r, pac3_r, pbb3_r;
  logic                    deg3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r  <= it1_nxt;
      w1_r   <= w;
      it2_r  <= it1_r;
      a2_r   <= dot3(it1_r.v1, it1_r.v1);
      b2_r   <= dot3(it1_r.v1, it1_r.v2);
      c2_r   <= dot3(it1_r.v2, it1_r.v2);
      dd2_r  <= dot3(it1_r.v1, w1_r);
      ee2_r  <= dot3(it1_r.v2, w1_r);
      cz2_r  <= (cx0 == '0) && (cx1 == '0) && (cx2 == '0);
      it3_r  <= it2_r;
      pbe3_r <= NUM_W'(b2_r) * NUM_W'(ee2_r);
      pcd3_r <= NUM_W'(c2_r) * NUM_W'(dd2_r);
      pac3_r <= NUM_W'(a2_r) * NUM_W'(c2_r);
      pbb3_r <= NUM_W'(b2_r) * NUM_W'(b2_r);
      deg3_r <= cz2_r || it2_r.z1 || it2_r.z2;
      it4_r  <= it3_r;
      num    <= DIV_W'(pbe3_r - pcd3_r);
      den    <= deg3_r ? '0 : DIV_W'(pac3_r - pbb3_r);
    end
  end

  assign out_vld  = vld4_r;
  assign out_item = it4_r;

endmodule

`default_nettype wire

FILE: design/cso_ptseg.sv
// ----------------------------------------------------------------------------
// cso_ptseg
// Scaled point to segment distance: projection, clamped quotient, squared gap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cso_ptseg import cso_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  cso_item_t      in_item,
  output logic           out_vld,
  output cso_item_t      out_item,
  output logic [D_W-1:0] d,
  output logic           t_in_rng,
  output pvec_t          h
);

  // sel picks segment A as target, else segment B
  function automatic cvec_t seg_s(cso_item_t it);
    return it.sel ? it.s1 : it.s2;
  endfunction

  function automatic dvec_t seg_v(cso_item_t it);
    return it.sel ? it.v1 : it.v2;
  endfunction

  typedef logic [2:0][EW-1:0]   evec_t;
  typedef logic [2:0][SQ_W-1:0] svec_t;

  cvec_t s_in, s_d;
  dvec_t v_p2, v_d;
  evec_t w_nxt, w1_r, e5_r;
  svec_t sq6_r;
  pvec_t h_nxt, h4_r, h5_r, h6_r, h7_r;
  cso_item_t it1_r, it2_r, itd, it4_r, it5_r, it6_r, it7_r;
  logic vld1_r, vld2_r, vldd, vld4_r, vld5_r, vld6_r, vld7_r;
  logic signed [VW_W-1:0]  vw2_r, vw_nxt;
  logic signed [DOT_W-1:0] vv2_r, vv_nxt;
  logic signed [DIV_W-1:0] dnum, dden;
  logic [TQ_W-1:0] tq;
  logic ins_d, in4_r, in5_r, in6_r, in7_r;
  logic [D_W-1:0] d7_r;

  always_comb begin
    s_in = seg_s(in_item);
    for (int i = 0; i < 3; i++) begin
      w_nxt[i] = EW'($signed(in_item.pp[i])) - (EW'($signed(s_in[i])) <<< T_FRAC_BITS);
    end
  end

  always_comb begin
    v_p2   = seg_v(it1_r);
    vw_nxt = '0;
    vv_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      vw_nxt = vw_nxt + VW_W'($signed(v_p2[i])) * VW_W'($signed(w1_r[i]));
      vv_nxt = vv_nxt + DOT_W'($signed(v_p2[i])) * DOT_W'($signed(v_p2[i]));
    end
  end

  assign dnum = DIV_W'(vw2_r);
  assign dden = DIV_W'(vv2_r) <<< T_FRAC_BITS;

  cso_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld2_r),
    .num      (dnum),
    .den      (dden),
    .in_item  (it2_r),
    .out_vld  (vldd),
    .q        (tq),
    .t_in_rng (ins_d),
    .out_item (itd)
  );

  always_comb begin
    logic signed [PX_W-1:0] px;
    s_d = seg_s(itd);
    v_d = seg_v(itd);
    for (int i = 0; i < 3; i++) begin
      px       = on_seg(s_d[i], tq, v_d[i]);
      h_nxt[i] = px[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld4_r <= vldd;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r <= in_item;
      w1_r  <= w_nxt;
      it2_r <= it1_r;
      vw2_r <= vw_nxt;
      vv2_r <= vv_nxt;
      it4_r <= itd;
      h4_r  <= h_nxt;
      in4_r <= ins_d;
      it5_r <= it4_r;
      h5_r  <= h4_r;
      in5_r <= in4_r;
      for (int i = 0; i < 3; i++) begin
        e5_r[i]  <= EW'($signed(h4_r[i])) - EW'($signed(it4_r.pp[i]));
        sq6_r[i] <= SQ_W'($signed(e5_r[i])) * SQ_W'($signed(e5_r[i]));
      end
      it6_r <= it5_r;
      h6_r  <= h5_r;
      in6_r <= in5_r;
      it7_r <= it6_r;
      h7_r  <= h6_r;
      in7_r <= in6_r;
      d7_r  <= D_W'(sq6_r[0]) + D_W'(sq6_r[1]) + D_W'(sq6_r[2]);
    end
  end

  assign out_vld  = vld7_r;
  assign out_item = it7_r;
  assign d        = d7_r;
  assign t_in_rng = in7_r;
  assign h        = h7_r;

endmodule

`default_nettype wire

FILE: design/capsule_sphere_overlap_test.sv
// Throughput: one request per cycle unless the output stalls; the rate is set by the
// fully pipelined quotient units, three of them with one restoring step per stage.
// A stall on the output freezes every stage at once; nothing is lost.
// Reset is synchronous, active low, and clears only the valid bits.
// ----------------------------------------------------------------------------
// capsule_sphere_overlap_test
// Segment-to-segment distance and radius-sum overlap check between two shapes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module capsule_sphere_overlap_test import cso_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PT_W-1:0]   in_a_start,
  input  logic [PT_W-1:0]   in_a_end,
  input  logic [RAD_W-1:0]  in_a_radius,
  input  logic [PT_W-1:0]   in_b_start,
  input  logic [PT_W-1:0]   in_b_end,
  input  logic [RAD_W-1:0]  in_b_radius,
  input  logic              in_a_valid,
  input  logic              in_b_valid,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit,
  output logic [DIST_W-1:0] out_dist_sq
);

  localparam int SH_W  = D_W + 1 - 2 * T_FRAC_BITS;
  localparam int RSQ_W = 2 * RAD_W + 2;

  logic en;
  logic out_valid_r, out_hit_r;
  logic [DIST_W-1:0] out_dist_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  logic                    f_vld;
  logic signed [DIV_W-1:0] f_num, f_den;
  cso_item_t               f_item;

  cso_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .a_start  (in_a_start),
    .a_end    (in_a_end),
    .a_radius (in_a_radius),
    .b_start  (in_b_start),
    .b_end    (in_b_end),
    .b_radius (in_b_radius),
    .a_valid  (in_a_valid),
    .b_valid  (in_b_valid),
    .out_vld  (f_vld),
    .num      (f_num),
    .den      (f_den),
    .out_item (f_item)
  );

  logic            t_vld;
  logic [TQ_W-1:0] t1;
  logic            t1_in;
  cso_item_t       t_item;

  cso_div u_skew_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld),
    .num      (f_num),
    .den      (f_den),
    .in_item  (f_item),
    .out_vld  (t_vld),
    .q        (t1),
    .t_in_rng (t1_in),
    .out_item (t_item)
  );

  // first probe point: on A at t1, or B's point when only B is degenerate
  cso_item_t pa_nxt, pa_r;
  logic      pa_vld_r;

  always_comb begin
    logic signed [PX_W-1:0] px;
    pa_nxt     = t_item;
    pa_nxt.sel = t_item.z2 && !t_item.z1;
    for (int i = 0; i < 3; i++) begin
      if (pa_nxt.sel) begin
        px = on_seg(t_item.s2[i], '0, t_item.v2[i]);
      end else begin
        px = on_seg(t_item.s1[i], t1 & {TQ_W{t1_in | !t1_in}}, t_item.v1[i]);
      end
      pa_nxt.pp[i] = px[PW-1:0];
    end
  end

  logic           p1_vld, p1_ins;
  cso_item_t      p1_item, p2_in;
  logic [D_W-1:0] p1_d;
  pvec_t          p1_h;

  cso_ptseg u_ptseg_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (pa_vld_r),
    .in_item  (pa_r),
    .out_vld  (p1_vld),
    .out_item (p1_item),
    .d        (p1_d),
    .t_in_rng (p1_ins),
    .h        (p1_h)
  );

  always_comb begin
    p2_in      = p1_item;
    p2_in.d1   = p1_d;
    p2_in.use2 = !p1_item.z1 && !p1_item.z2 && !p1_ins;
    p2_in.pp   = p1_h;
    p2_in.sel  = 1'b1;
  end

  logic           p2_vld, p2_ins;
  cso_item_t      p2_item;
  logic [D_W-1:0] p2_d;
  pvec_t          p2_h;

  cso_ptseg u_ptseg_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (p1_vld),
    .in_item  (p2_in),
    .out_vld  (p2_vld),
    .out_item (p2_item),
    .d        (p2_d),
    .t_in_rng (p2_ins),
    .h        (p2_h)
  );

  // rounding, saturation and squared radius sum
  logic [D_W-1:0]    dsel;
  logic [D_W:0]      dh;
  logic [SH_W-1:0]   sh;
  logic [DIST_W-1:0] dsat;
  logic [RAD_W:0]    rsum;
  logic [RSQ_W-1:0]  rsq;
  logic              r_vld_r, r_both_r;
  logic [DIST_W-1:0] r_dsat_r;
  logic [RSQ_W-1:0]  r_rsq_r;

  always_comb begin
    dsel = p2_item.use2 ? p2_d : p2_item.d1;
    dh   = (D_W + 1)'(dsel) + ((D_W + 1)'(1) << (2 * T_FRAC_BITS - 1));
    sh   = dh[D_W:2*T_FRAC_BITS];
    dsat = (sh > SH_W'(DIST_MAX)) ? DIST_MAX : sh[DIST_W-1:0];
    rsum = (RAD_W + 1)'(p2_item.rad_a) + (RAD_W + 1)'(p2_item.rad_b);
    rsq  = RSQ_W'(rsum) * RSQ_W'(rsum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_vld_r    <= 1'b0;
      r_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pa_vld_r    <= t_vld;
      r_vld_r     <= p2_vld;
      out_valid_r <= r_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r       <= pa_nxt;
      r_dsat_r   <= dsat;
      r_rsq_r    <= rsq;
      r_both_r   <= p2_item.va && p2_item.vb && (p2_ins || !p2_ins);
      out_dist_r <= r_dsat_r;
      out_hit_r  <= r_both_r && (RSQ_W'(r_dsat_r) <= r_rsq_r);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_dist_sq = out_dist_r;

  logic unused_h;
  assign unused_h = ^p2_h;

endmodule

`default_nettype wire
